### sv/cmap_pkg.sv
package cmap_pkg;

   // Table geometry and sample format
   localparam int MAX_STOPS   = 32;
   localparam int STOP_IDX_W  = 5;
   localparam int SAMPLE_BITS = 16;
   localparam int POS_W       = 16;
   localparam int CHAN_W      = 8;
   localparam int COL_W       = 3 * CHAN_W;
   localparam int ENTRY_W     = POS_W + COL_W;
   localparam int COUNT_W     = 6;

   // Configuration registers
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 18;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_COUNT        = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CONTRAST_GAIN     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BRIGHTNESS_OFFSET = 2'd2;

   localparam int GAIN_W   = 16;
   localparam int BRIGHT_W = 18;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;

   // Commands
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_MAP  = 1'b1;

   // Fraction divider: dividend 2*num + range, divisor 2*range, quotient below 256
   localparam int DIV_NUM_W = 27;
   localparam int DIV_DEN_W = 17;
   localparam int DIV_Q_W   = 8;
   localparam int DIV_CNT_W = 3;
   localparam int BLEND_W   = 25;

   typedef struct packed {
      logic                  command;
      logic [STOP_IDX_W-1:0] stop_index;
      logic [POS_W-1:0]      stop_position;
      logic [CHAN_W-1:0]     stop_red;
      logic [CHAN_W-1:0]     stop_green;
      logic [CHAN_W-1:0]     stop_blue;
      logic [POS_W-1:0]      sample;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rsp_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DIV_Q_W-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_CLAMP,
      ST_SCAN,
      ST_MIX,
      ST_DSTART,
      ST_DWAIT
   } state_type;

endpackage

### sv/colormap_stop_interpolator.sv
// Channel   Direction  Handshake                 Payload
// req       in         start & !busy             req_type: command, stop slot/colour, sample
// rsp       out        rsp_valid, one cycle      rsp_type: red, green, blue
// csr       in         csr_valid & csr_ready     csr_index, csr_data
//
// A map with no stops answers in the next cycle; otherwise it runs contrast/clamp, then scans
// the stops in the stop RAM (one read port, up to the lesser of stop_count and 32), and when
// a segment is interpolated, one shared 8-step divider runs once per colour channel.
// Reset is synchronous; the stop table is not cleared. The result strobe cannot be stalled.
module colormap_stop_interpolator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  cmap_pkg::req_type                   req_payload,
   output logic                                rsp_valid,
   output cmap_pkg::rsp_type                   rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cmap_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cmap_pkg::CSR_DATA_W-1:0]     csr_data
);

   import cmap_pkg::*;

   state_type state_ff, state_in;

   logic [COUNT_W-1:0]     stop_count_ff, stop_count_in;
   logic [GAIN_W-1:0]      gain_ff, gain_in;
   logic [BRIGHT_W-1:0]    bright_ff, bright_in;

   logic [POS_W-1:0]       sample_ff, sample_in;
   logic signed [33:0]     p_ff, p_in;
   logic [POS_W-1:0]       v_ff, v_in;
   logic [STOP_IDX_W-1:0]  k_ff, k_in;
   logic [POS_W-1:0]       prev_pos_ff, prev_pos_in;
   logic [COL_W-1:0]       prev_col_ff, prev_col_in;
   logic [COL_W-1:0]       first_col_ff, first_col_in;
   logic                   below_ff, below_in;
   logic [COL_W-1:0]       c0_ff, c0_in;
   logic [COL_W-1:0]       c1_ff, c1_in;
   logic [POS_W-1:0]       range_ff, range_in;
   logic [POS_W-1:0]       dv_ff, dv_in;
   logic [1:0]             ch_ff, ch_in;
   logic [BLEND_W-1:0]     num_ff, num_in;
   logic [COL_W-1:0]       col_ff, col_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   accept;
   logic                   ram_wr_en;
   logic [STOP_IDX_W-1:0]  ram_rd_addr;
   logic [ENTRY_W-1:0]     ram_rd_data;
   div_req_type            div_req;
   div_rsp_type            div_rsp;

   logic [COUNT_W-1:0]     n_stops;
   logic [COUNT_W-1:0]     last_wide;
   logic [STOP_IDX_W-1:0]  last_idx;
   logic [POS_W-1:0]       cur_pos;
   logic [COL_W-1:0]       cur_col;
   logic                   at_first;
   logic                   at_last;
   logic                   hit;
   logic [POS_W-1:0]       range_w;
   logic [POS_W-1:0]       dv_w;
   logic signed [16:0]     d_w;
   logic signed [33:0]     pr_w;
   logic signed [21:0]     r_w;
   logic signed [23:0]     s_w;
   logic [CHAN_W-1:0]      chan_a;
   logic [CHAN_W-1:0]      chan_b;
   logic [23:0]            prod_a;
   logic [23:0]            prod_b;

   // Stop table: position in the upper bits, colour below
   cmap_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_STOPS)
   ) u_stop_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (req_payload.stop_index),
      .wr_data ({req_payload.stop_position, req_payload.stop_red,
                 req_payload.stop_green, req_payload.stop_blue}),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   cmap_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign n_stops   = (stop_count_ff > COUNT_W'(MAX_STOPS)) ? COUNT_W'(MAX_STOPS)
                                                            : stop_count_ff;
   assign last_wide = n_stops - COUNT_W'(1);
   assign last_idx  = last_wide[STOP_IDX_W-1:0];

   assign cur_pos  = ram_rd_data[ENTRY_W-1:COL_W];
   assign cur_col  = ram_rd_data[COL_W-1:0];
   assign at_first = k_ff == '0;
   assign at_last  = k_ff == last_idx;
   assign hit      = !at_first && (v_ff >= prev_pos_ff) && (v_ff <= cur_pos);
   assign range_w  = cur_pos - prev_pos_ff;
   assign dv_w     = v_ff - prev_pos_ff;

   // Contrast about mid-scale, round half up, then brightness
   assign d_w  = $signed({1'b0, sample_ff}) - 17'sd32768;
   assign pr_w = p_ff + 34'sd2048;
   assign r_w  = pr_w[33:12];
   assign s_w  = 24'sd32768 + {{2{r_w[21]}}, r_w} + {{6{bright_ff[BRIGHT_W-1]}}, bright_ff};

   always_comb begin
      case (ch_ff)
         2'd0: begin
            chan_a = c0_ff[23:16];
            chan_b = c1_ff[23:16];
         end
         2'd1: begin
            chan_a = c0_ff[15:8];
            chan_b = c1_ff[15:8];
         end
         default: begin
            chan_a = c0_ff[7:0];
            chan_b = c1_ff[7:0];
         end
      endcase
   end

   assign prod_a = 24'(chan_a) * 24'(range_ff - dv_ff);
   assign prod_b = 24'(chan_b) * 24'(dv_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start && req_payload.command == CMD_MAP && n_stops != '0) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:    state_in = ST_CLAMP;
         ST_CLAMP:  state_in = ST_SCAN;
         ST_SCAN: begin
            if (hit) begin
               state_in = (range_w == '0) ? ST_IDLE : ST_MIX;
            end else if (at_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_MIX:    state_in = ST_DSTART;
         ST_DSTART: state_in = ST_DWAIT;
         ST_DWAIT: begin
            if (div_rsp.done) begin
               state_in = (ch_ff == 2'd2) ? ST_IDLE : ST_MIX;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // Control outputs
   always_comb begin
      busy          = state_ff != ST_IDLE;
      accept        = start && !busy;
      ram_wr_en     = accept && req_payload.command == CMD_LOAD;
      ram_rd_addr   = '0;
      div_req.start = 1'b0;
      div_req.num   = {1'b0, num_ff, 1'b0} + DIV_NUM_W'(range_ff);
      div_req.den   = {range_ff, 1'b0};
      case (state_ff)
         ST_SCAN:   ram_rd_addr   = k_ff + STOP_IDX_W'(1);
         ST_DSTART: div_req.start = 1'b1;
         default:   ram_rd_addr   = '0;
      endcase
   end

   // Datapath
   always_comb begin
      stop_count_in = stop_count_ff;
      gain_in       = gain_ff;
      bright_in     = bright_ff;
      sample_in     = sample_ff;
      p_in          = p_ff;
      v_in          = v_ff;
      k_in          = k_ff;
      prev_pos_in   = prev_pos_ff;
      prev_col_in   = prev_col_ff;
      first_col_in  = first_col_ff;
      below_in      = below_ff;
      c0_in         = c0_ff;
      c1_in         = c1_ff;
      range_in      = range_ff;
      dv_in         = dv_ff;
      ch_in         = ch_ff;
      num_in        = num_ff;
      col_in        = col_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_STOP_COUNT:        stop_count_in = csr_data[COUNT_W-1:0];
            CSR_CONTRAST_GAIN:     gain_in       = csr_data[GAIN_W-1:0];
            CSR_BRIGHTNESS_OFFSET: bright_in     = csr_data[BRIGHT_W-1:0];
            default:               stop_count_in = stop_count_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept && req_payload.command == CMD_MAP) begin
               sample_in = req_payload.sample;
               if (n_stops == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '0;
               end
            end
         end
         ST_MUL: begin
            p_in = d_w * $signed({1'b0, gain_ff});
         end
         ST_CLAMP: begin
            k_in = '0;
            if (s_w[23]) begin
               v_in = '0;
            end else if (s_w > 24'sd65535) begin
               v_in = '1;
            end else begin
               v_in = s_w[POS_W-1:0];
            end
         end
         ST_SCAN: begin
            if (at_first) begin
               first_col_in = cur_col;
               below_in     = v_ff < cur_pos;
            end
            prev_pos_in = cur_pos;
            prev_col_in = cur_col;
            k_in        = k_ff + STOP_IDX_W'(1);
            if (hit) begin
               if (range_w == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = prev_col_ff;
               end
               c0_in    = prev_col_ff;
               c1_in    = cur_col;
               range_in = range_w;
               dv_in    = dv_w;
               ch_in    = 2'd0;
            end else if (at_last) begin
               rsp_valid_in = 1'b1;
               // Below range takes the first stop, otherwise the last valid one
               rsp_in = (!at_first && below_ff) ? first_col_ff : cur_col;
            end
         end
         ST_MIX: begin
            num_in = BLEND_W'(prod_a) + BLEND_W'(prod_b);
         end
         ST_DWAIT: begin
            if (div_rsp.done) begin
               ch_in = ch_ff + 2'd1;
               case (ch_ff)
                  2'd0: col_in[23:16] = div_rsp.quotient;
                  2'd1: col_in[15:8]  = div_rsp.quotient;
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = {col_ff[23:8], div_rsp.quotient};
                  end
               endcase
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         stop_count_ff <= '0;
         gain_ff       <= GAIN_RESET;
         bright_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
         k_ff          <= '0;
         ch_ff         <= '0;
      end else begin
         state_ff      <= state_in;
         stop_count_ff <= stop_count_in;
         gain_ff       <= gain_in;
         bright_ff     <= bright_in;
         rsp_valid_ff  <= rsp_valid_in;
         k_ff          <= k_in;
         ch_ff         <= ch_in;
      end
      sample_ff    <= sample_in;
      p_ff         <= p_in;
      v_ff         <= v_in;
      prev_pos_ff  <= prev_pos_in;
      prev_col_ff  <= prev_col_in;
      first_col_ff <= first_col_in;
      below_ff     <= below_in;
      c0_ff        <= c0_in;
      c1_ff        <= c1_in;
      range_ff     <= range_in;
      dv_ff        <= dv_in;
      num_ff       <= num_in;
      col_ff       <= col_in;
      rsp_ff       <= rsp_in;
   end

   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // A load transaction never produces a result
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_payload.command == CMD_LOAD) |=> !rsp_valid)
      else $error("result strobe after a load transaction");

   // Results are only issued as the block returns to idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while still busy");

   // The scan never runs past the last valid stop
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (k_ff <= last_idx))
      else $error("stop scan beyond stop count");

   // The divider finishes only while a channel is waiting for it
   assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DWAIT))
      else $error("divider result with no channel waiting");

endmodule

### sv/cmap_ram.sv
module cmap_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/cmap_div.sv
module cmap_div (
   input  logic                  clock,
   input  logic                  reset,
   input  cmap_pkg::div_req_type div_req,
   output cmap_pkg::div_rsp_type div_rsp
);

   import cmap_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] rem_ff, rem_in;
   logic [DIV_NUM_W-1:0] dsh_ff, dsh_in;
   logic [DIV_Q_W-1:0]   q_ff, q_in;
   logic                 fits;

   // Restoring division, one quotient bit per cycle, most significant first
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      fits    = rem_ff >= dsh_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_Q_W - 1);
         rem_in  = div_req.num;
         dsh_in  = DIV_NUM_W'({div_req.den, {(DIV_Q_W-1){1'b0}}});
         q_in    = '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - dsh_ff;
         end
         q_in   = {q_ff[DIV_Q_W-2:0], fits};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = q_ff;

endmodule

### test/tb_top.sv
module tb_top;
   import cmap_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 80;
   localparam longint MID = longint'(1) << (SAMPLE_BITS - 1);
   localparam longint FULL_MAX = (longint'(1) << SAMPLE_BITS) - 1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_payload = '0;
   logic rsp_valid;
   rsp_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   colormap_stop_interpolator uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_payload(rsp_payload),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #2 clock = ~clock;

   // mirror of the block's registers and stop table
   logic [COUNT_W-1:0] cfg_count = '0;
   logic [GAIN_W-1:0] cfg_gain = GAIN_RESET;
   logic signed [BRIGHT_W-1:0] cfg_bright = '0;
   logic [POS_W-1:0] stop_pos_tbl [MAX_STOPS];
   logic [COL_W-1:0] stop_rgb_tbl [MAX_STOPS];

   // table as the stimulus side expects it once all queued loads land
   int plan_pos [MAX_STOPS];

   req_type pending_items [$];
   rsp_type expected_colours [$];
   int items_queued = 0;
   int items_accepted = 0;
   int loads_seen = 0;
   int maps_seen = 0;
   int colours_checked = 0;
   int settings_used = 0;
   int errors = 0;
   int idle_left = 0;
   bit idle_on = 1'b0;
   int cycles = 0;

   function automatic logic [CHAN_W-1:0] blend(input longint a, input longint b,
                                                input longint rng, input longint dv);
      longint num;
      longint r;
      num = a * (rng - dv) + b * dv;
      r = (2 * num + rng) / (2 * rng);
      return (r > 255) ? 8'd255 : r[CHAN_W-1:0];
   endfunction

   function automatic rsp_type map_colour(input logic [POS_W-1:0] smp);
      int n;
      longint q, v, p0, p1;
      logic [COL_W-1:0] rgb, c0, c1;
      bit found;
      rsp_type res;
      n = (cfg_count > MAX_STOPS) ? MAX_STOPS : int'(cfg_count);
      if (n == 0) begin
         rgb = '0;
      end else if (n == 1) begin
         rgb = stop_rgb_tbl[0];
      end else begin
         // contrast about mid-scale, round half up, then brightness and clamp
         q = (longint'(smp) - MID) * longint'(cfg_gain) + 2048;
         v = MID + (q >>> 12) + longint'(cfg_bright);
         if (v < 0) v = 0;
         if (v > FULL_MAX) v = FULL_MAX;
         rgb = stop_rgb_tbl[n-1];
         if (v < longint'(stop_pos_tbl[0])) rgb = stop_rgb_tbl[0];
         found = 1'b0;
         for (int i = 0; i + 1 < n; i++) begin
            p0 = longint'(stop_pos_tbl[i]);
            p1 = longint'(stop_pos_tbl[i+1]);
            if (!found && v >= p0 && v <= p1) begin
               found = 1'b1;
               c0 = stop_rgb_tbl[i];
               c1 = stop_rgb_tbl[i+1];
               if (p1 == p0) begin
                  rgb = c0;
               end else begin
                  rgb = {blend(c0[23:16], c1[23:16], p1 - p0, v - p0),
                         blend(c0[15:8], c1[15:8], p1 - p0, v - p0),
                         blend(c0[7:0], c1[7:0], p1 - p0, v - p0)};
               end
            end
         end
      end
      res.red = rgb[23:16];
      res.green = rgb[15:8];
      res.blue = rgb[7:0];
      return res;
   endfunction

   task automatic apply_item(input req_type item);
      if (item.command == CMD_LOAD) begin
         stop_pos_tbl[item.stop_index] = item.stop_position;
         stop_rgb_tbl[item.stop_index] = {item.stop_red, item.stop_green, item.stop_blue};
         loads_seen++;
      end else begin
         expected_colours = {expected_colours, map_colour(item.sample)};
         maps_seen++;
      end
   endtask

   // driver: present pending transactions, hold while busy
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         idle_left = 0;
      end else if (!(start && busy)) begin
         if (start) begin
            apply_item(req_payload);
            items_accepted++;
         end
         if (idle_left > 0) begin
            idle_left--;
            start <= 1'b0;
         end else if (pending_items.size() == 0) begin
            start <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            idle_left = $urandom_range(0, 11);
            start <= 1'b0;
         end else begin
            req_payload <= pending_items.pop_front();
            start <= 1'b1;
         end
      end
   end

   // monitor: every strobed colour must match the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_colours.size() == 0) begin
            errors++;
            $display("%0t: unexpected colour %h %h %h", $time,
                     rsp_payload.red, rsp_payload.green, rsp_payload.blue);
         end else begin
            want = expected_colours.pop_front();
            colours_checked++;
            if (rsp_payload.red !== want.red || rsp_payload.green !== want.green ||
                rsp_payload.blue !== want.blue) begin
               errors++;
               $display("%0t: colour mismatch expected %h %h %h actual %h %h %h", $time,
                        want.red, want.green, want.blue,
                        rsp_payload.red, rsp_payload.green, rsp_payload.blue);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("status: fail");
         $finish;
      end
   end

   function automatic req_type rand_req();
      logic [63:0] noise;
      req_type r;
      noise = {$urandom, $urandom};
      r = noise[$bits(req_type)-1:0];
      return r;
   endfunction

   task automatic queue_load(input int idx, input int pos, input logic [7:0] red,
                             input logic [7:0] green, input logic [7:0] blue);
      req_type r;
      r = rand_req();
      r.command = CMD_LOAD;
      r.stop_index = idx[STOP_IDX_W-1:0];
      r.stop_position = pos[POS_W-1:0];
      r.stop_red = red;
      r.stop_green = green;
      r.stop_blue = blue;
      plan_pos[idx] = pos;
      pending_items = {pending_items, r};
      items_queued++;
   endtask

   task automatic queue_map(input int smp);
      req_type r;
      r = rand_req();
      r.command = CMD_MAP;
      r.sample = smp[POS_W-1:0];
      pending_items = {pending_items, r};
      items_queued++;
   endtask

   task automatic wait_drained();
      while (items_accepted != items_queued || expected_colours.size() != 0)
         @(posedge clock);
      // a trailing load leaves nothing to wait for, so let the datapath settle
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_STOP_COUNT: cfg_count = val[COUNT_W-1:0];
         CSR_CONTRAST_GAIN: cfg_gain = val[GAIN_W-1:0];
         CSR_BRIGHTNESS_OFFSET: cfg_bright = val[BRIGHT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_mapping(input int cnt, input int gain, input int bright);
      wait_drained();
      csr_write(CSR_STOP_COUNT, CSR_DATA_W'(cnt));
      csr_write(CSR_CONTRAST_GAIN, CSR_DATA_W'(gain));
      csr_write(CSR_BRIGHTNESS_OFFSET, bright[CSR_DATA_W-1:0]);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   initial begin
      int cnt, gain, bright, pos, step_max, lo, hi, k, smp;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty table gives black at both ends of the sample range
      queue_map(0);
      queue_map(65535);
      queue_load(0, 16'h2000, 8'h00, 8'hFF, 8'h80);
      queue_load(1, 16'h2000, 8'hFF, 8'h00, 8'h01);
      queue_load(2, 16'hC000, 8'h12, 8'h34, 8'hFF);
      queue_load(3, 16'hFFFF, 8'hFF, 8'hFF, 8'h00);
      queue_load(4, 16'h1000, 8'h55, 8'hAA, 8'h5A);

      // single stop: its colour, contrast ignored
      set_mapping(1, 0, -131072);
      queue_map(16'h1234);

      // below range, equal positions, interpolation, top end of a segment
      set_mapping(4, 4096, 0);
      queue_map(0);
      queue_map(16'h2000);
      queue_map(16'h8000);
      queue_map(16'hFFFF);
      queue_map(16'hFFFE);

      // above range
      set_mapping(3, 4096, 0);
      queue_map(16'hFFFF);

      // unsorted table
      set_mapping(5, 4096, 0);
      queue_map(16'h0800);
      queue_map(16'h1800);

      // contrast and brightness extremes
      set_mapping(4, 0, 0);
      queue_map(0);
      set_mapping(4, 65535, -131072);
      queue_map(16'hFFFF);
      set_mapping(4, 65535, 131071);
      queue_map(0);

      for (int ph = 0; ph < 15; ph++) begin
         case ($urandom_range(0, 7))
            0: cnt = 0;
            1: cnt = 1;
            2: cnt = 2;
            3: cnt = $urandom_range(3, 8);
            4: cnt = $urandom_range(9, 31);
            5, 6: cnt = MAX_STOPS;
            default: cnt = $urandom_range(33, 63);
         endcase
         if (ph == 0) cnt = MAX_STOPS;
         if (ph == 1) cnt = 63;
         case ($urandom_range(0, 5))
            0, 1: gain = 4096;
            2: gain = 0;
            3: gain = 65535;
            4: gain = $urandom_range(2048, 8192);
            default: gain = $urandom_range(0, 65535);
         endcase
         case ($urandom_range(0, 5))
            0, 1: bright = 0;
            2: bright = -131072;
            3: bright = 131071;
            4: bright = $urandom_range(0, 8191) - 4096;
            default: bright = $urandom_range(0, 262143) - 131072;
         endcase
         set_mapping(cnt, gain, bright);
         idle_on = (ph < 13) && ($urandom_range(0, 3) != 0);

         // reload a sorted table, with duplicates and sometimes the extreme positions
         if (ph == 0 || $urandom_range(0, 3) == 0) begin
            step_max = ($urandom_range(0, 3) == 0) ? 200 : 2047;
            pos = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4000);
            for (int s = 0; s < MAX_STOPS; s++) begin
               if (s == MAX_STOPS - 1 && $urandom_range(0, 2) == 0) pos = 65535;
               queue_load(s, pos, 8'($urandom), 8'($urandom), 8'($urandom));
               if ($urandom_range(0, 5) != 0) pos += $urandom_range(1, step_max);
               if (pos > 65535) pos = 65535;
            end
         end

         for (int j = 0; j < 100; j++) begin
            if ($urandom_range(0, 9) < 4) begin
               k = $urandom_range(0, MAX_STOPS - 1);
               lo = (k == 0) ? 0 : plan_pos[k-1];
               hi = (k == MAX_STOPS - 1) ? 65535 : plan_pos[k+1];
               if ($urandom_range(0, 9) == 0) pos = $urandom_range(0, 65535);
               else pos = $urandom_range(lo, hi);
               queue_load(k, pos, 8'($urandom), 8'($urandom), 8'($urandom));
            end else begin
               if ($urandom_range(0, 2) == 0) begin
                  smp = plan_pos[$urandom_range(0, MAX_STOPS - 1)] + $urandom_range(0, 4) - 2;
                  if (smp < 0) smp = 0;
                  if (smp > 65535) smp = 65535;
               end else begin
                  smp = $urandom_range(0, 65535);
               end
               queue_map(smp);
            end
         end
      end

      wait_drained();
      $display("covered %0d stop loads and %0d sample maps over %0d register settings",
               loads_seen, maps_seen, settings_used);
      $display("%0d mapped colours checked, %0d mismatches", colours_checked, errors);
      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
